// ===== sv/lkv_pkg.sv =====
// Shared types and constants for the LRU key-value cache.
// Used by lkv_store, lkv_recency and lru_key_value_cache; no dependencies.
`default_nettype none

package lkv_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned CAP_W  = 5;

  localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
  localparam logic [DATA_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

  localparam logic KIND_GET = 1'b0;
  localparam logic KIND_SET = 1'b1;

  // Recency table update requested by the sequencer
  typedef enum logic [1:0] {
    REC_NONE,
    REC_TOUCH,
    REC_INSERT
  } rec_op_t;

  typedef struct packed {
    rec_op_t op;
    logic    evict;
  } rec_cmd_t;

endpackage

`default_nettype wire

// ===== sv/lkv_store.sv =====
// Key and value memories of the LRU cache: one registered read port,
// one write port each. Depends on lkv_pkg.
`default_nettype none

module lkv_store #(
  parameter int unsigned ENTRIES = 16
) (
  input  wire logic                             clk,
  input  wire logic [$clog2(ENTRIES)-1:0]       rd_addr,
  output logic signed [lkv_pkg::DATA_W-1:0]     rd_key,
  output logic signed [lkv_pkg::DATA_W-1:0]     rd_value,
  input  wire logic                             wr_key_en,
  input  wire logic                             wr_val_en,
  input  wire logic [$clog2(ENTRIES)-1:0]       wr_addr,
  input  wire logic signed [lkv_pkg::DATA_W-1:0] wr_key,
  input  wire logic signed [lkv_pkg::DATA_W-1:0] wr_value
);
  import lkv_pkg::*;

  logic signed [DATA_W-1:0] key_mem   [ENTRIES];
  logic signed [DATA_W-1:0] value_mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_key_en) begin
      key_mem[wr_addr] <= wr_key;
    end
    rd_key <= key_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_val_en) begin
      value_mem[wr_addr] <= wr_value;
    end
    rd_value <= value_mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== sv/lkv_recency.sv =====
// Valid bits, recency ranks and entry count of the LRU cache, updated
// in one step per command. Depends on lkv_pkg.
`default_nettype none

module lkv_recency #(
  parameter int unsigned ENTRIES = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire lkv_pkg::rec_cmd_t                cmd,
  input  wire logic [$clog2(ENTRIES)-1:0]       slot,
  input  wire logic [$clog2(ENTRIES)-1:0]       evict_slot,
  input  wire logic [$clog2(ENTRIES)-1:0]       hit_rank,
  input  wire logic [$clog2(ENTRIES)-1:0]       rd_idx,
  output logic                                  rd_valid,
  output logic [$clog2(ENTRIES)-1:0]            rd_rank,
  output logic [$clog2(ENTRIES+1)-1:0]          count
);
  import lkv_pkg::*;

  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

  logic [ENTRIES-1:0] valid;
  logic [IDX_W-1:0]   rank [ENTRIES];
  logic [ENTRIES-1:0] keep;

  assign rd_valid = valid[rd_idx];
  assign rd_rank  = rank[rd_idx];

  // Entries that stay valid through an insert (the victim drops out)
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      keep[i] = valid[i] && !(cmd.evict && (IDX_W'(i) == evict_slot));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      count <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank[i] <= '0;
      end
    end else begin
      unique case (cmd.op)
        REC_NONE: begin
        end
        REC_TOUCH: begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (valid[i] && (rank[i] < hit_rank)) begin
              rank[i] <= rank[i] + IDX_W'(1);
            end
          end
          rank[slot] <= '0;
        end
        REC_INSERT: begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (IDX_W'(i) == slot) begin
              valid[i] <= 1'b1;
              rank[i]  <= '0;
            end else begin
              valid[i] <= keep[i];
              rank[i]  <= keep[i] ? rank[i] + IDX_W'(1) : '0;
            end
          end
          if (!cmd.evict) begin
            count <= count + CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/lru_key_value_cache.sv =====
// Top level of the fully associative LRU key-value cache: sequencer,
// shared key comparator and output register. Depends on lkv_pkg,
// lkv_store and lkv_recency.
// Usage:
//   Input items (in_valid / in_stall) carry kind, key and value. A GET
//   returns one result item (hit, read_value) on out_valid / out_stall;
//   a miss returns hit 0 with read_value all ones. A SET stores the value,
//   inserting a new key as most recent and evicting the least recent entry
//   when capacity entries are held; it returns nothing. Write capacity
//   through cfg_wen / cfg_wdata while idle; zero acts as 1, values above
//   ENTRIES act as ENTRIES.
// Timing:
//   One equality comparator walks the key memory one entry per cycle,
//   the S_LAST state finishes the last compare and the S_COMMIT state
//   updates memories and ranks. The GET result and the drop of in_stall
//   both come with the commit, so no new item is taken before the last
//   one is through; the serial key scan sets how long an item takes.
//   A stalled result holds the next GET in commit; SETs go on.
// Reset (rst, synchronous) clears entries, count and out_valid and sets
//   capacity to 16; in_stall stays high while rst is high.
`default_nettype none

module lru_key_value_cache #(
  parameter int unsigned ENTRIES = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // configuration
  input  wire logic                              cfg_wen,
  input  wire logic [lkv_pkg::CAP_W-1:0]         cfg_wdata,
  // input items
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              kind,
  input  wire logic signed [lkv_pkg::DATA_W-1:0] key,
  input  wire logic signed [lkv_pkg::DATA_W-1:0] value,
  // result items
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   hit,
  output logic signed [lkv_pkg::DATA_W-1:0]      read_value
);
  import lkv_pkg::*;

  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam int unsigned CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_COMMIT
  } state_t;

  state_t state;

  logic [CAP_W-1:0] capacity;

  // Held request
  logic                     req_kind;
  logic signed [DATA_W-1:0] req_key;
  logic signed [DATA_W-1:0] req_value;

  // Scan pointer and compare stage
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] cmp_idx;
  logic             cmp_vld;

  // Scan results
  logic                     found;
  logic [IDX_W-1:0]         found_idx;
  logic [IDX_W-1:0]         found_rank;
  logic signed [DATA_W-1:0] found_val;
  logic                     oldest_any;
  logic [IDX_W-1:0]         oldest_idx;
  logic [IDX_W-1:0]         oldest_rank;
  logic                     free_any;
  logic [IDX_W-1:0]         free_idx;

  // Store and recency interface
  logic signed [DATA_W-1:0] key_rd;
  logic signed [DATA_W-1:0] value_rd;
  logic                     rd_valid;
  logic [IDX_W-1:0]         rd_rank;
  logic [CNT_W-1:0]         count;
  rec_cmd_t                 rec_cmd;
  logic [IDX_W-1:0]         wr_slot;
  logic                     wr_key_en;
  logic                     wr_val_en;

  logic             key_match;
  logic             older;
  logic             first_free;
  logic [CMP_W-1:0] cap_ext;
  logic [CMP_W-1:0] eff_cap;
  logic             do_evict;
  logic [IDX_W-1:0] ins_slot;
  logic             out_free;
  logic             commit_go;

  assign in_stall = (state != S_IDLE) || rst;

  // Shared comparator: one stored key against the request per cycle
  assign key_match  = cmp_vld && rd_valid && (key_rd == req_key);
  assign older      = cmp_vld && rd_valid && (!oldest_any || (rd_rank > oldest_rank));
  assign first_free = cmp_vld && !rd_valid && !free_any;

  // Clamp capacity to 1..ENTRIES
  assign cap_ext = CMP_W'(capacity);
  always_comb begin
    priority if (cap_ext == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(ENTRIES)) begin
      eff_cap = CMP_W'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign do_evict = CMP_W'(count) >= eff_cap;

  // New key goes to the lowest free slot, counting the victim as free
  always_comb begin
    if (!do_evict) begin
      ins_slot = free_idx;
    end else if (free_any && (free_idx < oldest_idx)) begin
      ins_slot = free_idx;
    end else begin
      ins_slot = oldest_idx;
    end
  end

  assign out_free  = !out_valid || !out_stall;
  assign commit_go = (state == S_COMMIT) && ((req_kind == KIND_SET) || out_free);

  assign wr_slot   = found ? found_idx : ins_slot;
  assign wr_key_en = commit_go && (req_kind == KIND_SET) && !found;
  assign wr_val_en = commit_go && (req_kind == KIND_SET);

  always_comb begin
    rec_cmd.evict = do_evict;
    if (!commit_go) begin
      rec_cmd.op = REC_NONE;
    end else if (found) begin
      rec_cmd.op = REC_TOUCH;
    end else if (req_kind == KIND_SET) begin
      rec_cmd.op = REC_INSERT;
    end else begin
      rec_cmd.op = REC_NONE;
    end
  end

  lkv_store #(
    .ENTRIES (ENTRIES)
  ) u_store (
    .clk       (clk),
    .rd_addr   (idx),
    .rd_key    (key_rd),
    .rd_value  (value_rd),
    .wr_key_en (wr_key_en),
    .wr_val_en (wr_val_en),
    .wr_addr   (wr_slot),
    .wr_key    (req_key),
    .wr_value  (req_value)
  );

  lkv_recency #(
    .ENTRIES (ENTRIES)
  ) u_recency (
    .clk        (clk),
    .rst        (rst),
    .cmd        (rec_cmd),
    .slot       (wr_slot),
    .evict_slot (oldest_idx),
    .hit_rank   (found_rank),
    .rd_idx     (cmp_idx),
    .rd_valid   (rd_valid),
    .rd_rank    (rd_rank),
    .count      (count)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      cmp_vld   <= 1'b0;
      capacity  <= CAP_RESET;
    end else begin
      if (cfg_wen) begin
        capacity <= cfg_wdata;
      end

      // Load a GET result at commit; otherwise drop the result once taken
      if (commit_go && (req_kind == KIND_GET)) begin
        out_valid  <= 1'b1;
        hit        <= found;
        read_value <= found ? found_val : MISS_VALUE;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      // Track hit, oldest entry and first free slot as the scan goes by
      if (key_match && !found) begin
        found      <= 1'b1;
        found_idx  <= cmp_idx;
        found_rank <= rd_rank;
        found_val  <= value_rd;
      end
      if (older) begin
        oldest_any  <= 1'b1;
        oldest_idx  <= cmp_idx;
        oldest_rank <= rd_rank;
      end
      if (first_free) begin
        free_any <= 1'b1;
        free_idx <= cmp_idx;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            req_kind   <= kind;
            req_key    <= key;
            req_value  <= value;
            idx        <= '0;
            found      <= 1'b0;
            oldest_any <= 1'b0;
            free_any   <= 1'b0;
            oldest_idx <= '0;
            free_idx   <= '0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          cmp_vld <= 1'b1;
          cmp_idx <= idx;
          idx     <= idx + IDX_W'(1);
          if (idx == IDX_W'(ENTRIES - 1)) begin
            state <= S_LAST;
          end
        end
        S_LAST: begin
          cmp_vld <= 1'b0;
          state   <= S_COMMIT;
        end
        S_COMMIT: begin
          // Hold here while a GET result cannot be loaded
          if (commit_go) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/lru_key_value_cache_chk.sv =====
// Port-level checker for lru_key_value_cache and its bind statement.
// Depends on lkv_pkg and the top level's port list.
`default_nettype none

module lru_key_value_cache_chk (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              in_valid,
  input wire logic                              in_stall,
  input wire logic                              kind,
  input wire logic                              out_valid,
  input wire logic                              out_stall,
  input wire logic                              hit,
  input wire logic signed [lkv_pkg::DATA_W-1:0] read_value
);
  import lkv_pkg::*;

  // One item at a time: busy right after an item is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after accepting an item");

  // A miss always reports all ones
  a_miss_value: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !hit) |-> (read_value == MISS_VALUE))
    else $error("miss result without all-ones value");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(hit) && $stable(read_value)))
    else $error("stalled result changed");

  // Reset leaves no result pending
  a_reset_clears: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  // A set never produces a result on its own
  a_set_silent: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && (kind == KIND_SET) && !out_valid) |=> !out_valid)
    else $error("result appeared for a set");

endmodule

bind lru_key_value_cache lru_key_value_cache_chk u_chk (.*);

`default_nettype wire

// ===== tb/tb_lru_key_value_cache.sv =====
// Self-checking testbench for lru_key_value_cache: a directed table, then random
// get/set traffic over several capacity settings, checked by an in-bench LRU predictor.
// Depends on lkv_pkg and the lru_key_value_cache RTL only.
module tb_lru_key_value_cache;
  timeunit 1ns;
  timeprecision 1ps;
  import lkv_pkg::*;

  localparam int SLOTS          = 16;              // ENTRIES of the instance
  localparam int SETTLE_CYCLES  = 2 * (SLOTS + 3); // lets a trailing item finish
  localparam int HOLD_CYCLES    = 400;             // long receiver hold-off
  localparam int POOL           = 24;
  localparam int PHASES         = 10;
  localparam int ITEMS_PER_PHASE = 55;
  localparam int PRESSURE_PHASE = 3;
  localparam int PAUSE_PHASE    = 5;

  // Capacity per random phase and how many distinct keys that phase draws from.
  // Zero acts as one entry and values above ENTRIES act as ENTRIES.
  localparam logic [CAP_W-1:0] PHASE_CAPS [PHASES] =
    '{5'd16, 5'd1, 5'd3, 5'd8, 5'd0, 5'd31, 5'd17, 5'd2, 5'd5, 5'd16};
  localparam int PHASE_SPAN [PHASES] = '{20, 3, 5, 10, 2, 18, 20, 4, 7, 19};
  localparam logic [DATA_W-1:0] EDGE_VALUES [4] =
    '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};

  typedef struct packed {
    logic              hit;
    logic [DATA_W-1:0] data;
  } read_t;

  // One directed step: either a capacity write (value holds the setting) or an item.
  // Where typed is set, the expected result is the one written in the row.
  typedef struct packed {
    bit                is_cfg;
    logic              kind;
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] value;
    bit                typed;
    logic              hit;
    logic [DATA_W-1:0] data;
  } step_row_t;

  // Directed part, starting from reset (capacity 16, cache empty).
  step_row_t script [25] = '{
    '{1'b0, KIND_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, MISS_VALUE},   // empty cache
    '{1'b0, KIND_GET, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0, MISS_VALUE},
    '{1'b0, KIND_SET, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0, 32'h0},
    '{1'b0, KIND_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 32'h8000_0000},
    '{1'b0, KIND_SET, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
    '{1'b0, KIND_GET, 32'h8000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h7FFF_FFFF},
    '{1'b0, KIND_SET, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
    // a stored all-ones value must still come back with hit set
    '{1'b0, KIND_GET, 32'h0000_0000, 32'h5555_AAAA, 1'b1, 1'b1, 32'hFFFF_FFFF},
    '{1'b0, KIND_SET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 32'h0},        // overwrite
    '{1'b0, KIND_GET, 32'h7FFF_FFFF, 32'hDEAD_BEEF, 1'b1, 1'b1, 32'h0000_0000},
    '{1'b0, KIND_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b0, MISS_VALUE},
    // lower capacity under the current fill of three: nothing drops until an insert
    '{1'b1, KIND_GET, 32'h0, 32'd2, 1'b0, 1'b0, 32'h0},
    '{1'b0, KIND_SET, 32'h0000_0001, 32'h0000_0001, 1'b0, 1'b0, 32'h0},
    '{1'b0, KIND_GET, 32'h8000_0000, 32'h0000_0000, 1'b1, 1'b0, MISS_VALUE},   // was oldest
    '{1'b0, KIND_GET, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{1'b0, KIND_SET, 32'h0000_0002, 32'h0000_0002, 1'b0, 1'b0, 32'h0},
    '{1'b0, KIND_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
    // zero capacity acts as one
    '{1'b1, KIND_GET, 32'h0, 32'd0, 1'b0, 1'b0, 32'h0},
    '{1'b0, KIND_SET, 32'h0000_0003, 32'h0000_0003, 1'b0, 1'b0, 32'h0},
    '{1'b0, KIND_GET, 32'h0000_0003, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
    // capacity above ENTRIES acts as ENTRIES
    '{1'b1, KIND_GET, 32'h0, 32'd31, 1'b0, 1'b0, 32'h0},
    '{1'b0, KIND_SET, 32'h0000_0004, 32'h0000_0004, 1'b0, 1'b0, 32'h0},
    '{1'b0, KIND_GET, 32'h0000_0001, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{1'b1, KIND_GET, 32'h0, 32'd16, 1'b0, 1'b0, 32'h0},
    '{1'b0, KIND_GET, 32'h0000_0002, 32'h0000_0000, 1'b0, 1'b0, 32'h0}
  };

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      cfg_wen;
  logic [CAP_W-1:0]          cfg_wdata;
  logic                      in_valid;
  logic                      in_stall;
  logic                      kind;
  logic signed [DATA_W-1:0]  key;
  logic signed [DATA_W-1:0]  value;
  logic                      out_valid;
  logic                      out_stall;
  logic                      hit;
  logic signed [DATA_W-1:0]  read_value;

  // Predictor state: a shadow copy of the cache contents and recency order.
  logic [DATA_W-1:0] slot_key  [SLOTS];
  logic [DATA_W-1:0] slot_val  [SLOTS];
  bit                slot_live [SLOTS];
  int unsigned       slot_age  [SLOTS];   // 0 is the most recent live entry
  int unsigned       live_count = 0;
  logic [CAP_W-1:0]  cap_reg = CAP_RESET;

  read_t pending_reads [$];   // results of accepted gets, oldest first

  bit hold_off_req = 1'b0;   // sender asks the receiver for one long hold-off
  bit rx_gaps      = 1'b1;   // receiver stalls at random while set

  int error_count = 0;
  int n_gets = 0, n_hits = 0, n_sets = 0, n_evictions = 0, n_cfg = 0, n_results = 0;

  lru_key_value_cache #(.ENTRIES(SLOTS)) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .key        (key),
    .value      (value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .hit        (hit),
    .read_value (read_value)
  );

  always #6 clk = ~clk;

  // Move an entry to the front: every live entry younger than it ages by one.
  function automatic void promote(int s);
    for (int i = 0; i < SLOTS; i++)
      if (slot_live[i] && slot_age[i] < slot_age[s]) slot_age[i]++;
    slot_age[s] = 0;
  endfunction

  // Apply one item to the shadow cache; a get yields the read it must return.
  function automatic void predict_access(input logic k, input logic [DATA_W-1:0] ky,
                                         input logic [DATA_W-1:0] v,
                                         output bit has_read, output read_t res);
    int found;
    int oldest;
    int free_slot;
    int unsigned lim;
    found = -1;
    for (int i = 0; i < SLOTS; i++)
      if (found < 0 && slot_live[i] && slot_key[i] == ky) found = i;
    res.hit  = 1'b0;
    res.data = MISS_VALUE;
    has_read = (k == KIND_GET);
    if (k == KIND_GET) begin
      n_gets++;
      if (found >= 0) begin
        promote(found);
        res.hit  = 1'b1;
        res.data = slot_val[found];
        n_hits++;
      end
      return;
    end
    n_sets++;
    if (found >= 0) begin
      slot_val[found] = v;
      promote(found);
      return;
    end
    // New key: clamp the capacity, evict the oldest if full, take the lowest free slot.
    lim = (cap_reg == 0) ? 1 : ((cap_reg > SLOTS) ? SLOTS : cap_reg);
    if (live_count >= lim) begin
      oldest = -1;
      for (int i = 0; i < SLOTS; i++)
        if (slot_live[i] && (oldest < 0 || slot_age[i] > slot_age[oldest])) oldest = i;
      if (oldest >= 0) begin
        slot_live[oldest] = 1'b0;
        slot_age[oldest]  = 0;
        live_count--;
        n_evictions++;
      end
    end
    free_slot = -1;
    for (int i = 0; i < SLOTS; i++)
      if (free_slot < 0 && !slot_live[i]) free_slot = i;
    if (free_slot < 0) return;
    for (int i = 0; i < SLOTS; i++)
      if (slot_live[i]) slot_age[i]++;
    slot_key[free_slot]  = ky;
    slot_val[free_slot]  = v;
    slot_live[free_slot] = 1'b1;
    slot_age[free_slot]  = 0;
    live_count++;
  endfunction

  function automatic void flag_mismatch(string what, logic [DATA_W-1:0] want,
                                        logic [DATA_W-1:0] got);
    error_count++;
    if (error_count <= 10)
      $display("MISMATCH %s: expected %h, got %h at %0t", what, want, got, $time);
  endfunction

  // Offer one item and hold it until accepted; predict at the accepting edge.
  // Valid is left high so a back-to-back item needs no second assignment.
  task automatic offer_item(input logic k, input logic [DATA_W-1:0] ky,
                            input logic [DATA_W-1:0] v, input bit typed,
                            input read_t typed_res);
    bit    has_read;
    read_t res;
    in_valid <= 1'b1;
    kind     <= k;
    key      <= ky;
    value    <= v;
    do @(posedge clk); while (in_stall);
    predict_access(k, ky, v, has_read, res);
    if (has_read) pending_reads.push_back(typed ? typed_res : res);
  endtask

  // Drop valid for a burst; scramble the payload so an idle bus is not a clean one.
  task automatic sender_gap(int unsigned cycles);
    in_valid <= 1'b0;
    kind     <= 1'($urandom);
    key      <= $urandom;
    value    <= $urandom;
    repeat (cycles) @(posedge clk);
  endtask

  // Hold off until every get has answered, then let a trailing set finish its commit.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] c);
    wait_for_results();
    cfg_wen   <= 1'b1;
    cfg_wdata <= c;
    @(posedge clk);
    cfg_wen <= 1'b0;
    cap_reg = c;
    n_cfg++;
  endtask

  // Result checker: compare each accepted result with the oldest pending get.
  always @(posedge clk) begin
    read_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_reads.size() == 0) begin
        flag_mismatch("result with no pending get", 'x, read_value);
      end else begin
        want = pending_reads.pop_front();
        n_results++;
        if (hit !== want.hit) flag_mismatch("hit", DATA_W'(want.hit), DATA_W'(hit));
        if (read_value !== want.data) flag_mismatch("read_value", want.data, read_value);
      end
    end
  end

  // Receiver: quiet stretches, random stall bursts, and one long hold-off on request.
  // Each branch advances at least one edge after its last assignment.
  initial begin : receiver
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end else if (rx_gaps && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    step_row_t         row;
    read_t             typed_res;
    logic [DATA_W-1:0] pool [POOL];
    logic              k;
    logic [DATA_W-1:0] ky;
    logic [DATA_W-1:0] v;
    bit                tx_gaps;

    rst       <= 1'b1;
    cfg_wen   <= 1'b0;
    cfg_wdata <= '0;
    in_valid  <= 1'b0;
    kind      <= KIND_GET;
    key       <= '0;
    value     <= '0;
    typed_res = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: extremes, overwrite, eviction after lowering capacity, clamping.
    foreach (script[r]) begin
      row = script[r];
      if (row.is_cfg) begin
        write_capacity(row.value[CAP_W-1:0]);
      end else begin
        typed_res.hit  = row.hit;
        typed_res.data = row.data;
        offer_item(row.kind, row.key, row.value, row.typed, typed_res);
      end
    end

    // Random part: each phase sets a capacity, then draws keys mostly from a small
    // pool so gets hit and sets evict, with a few fully random keys for misses.
    for (int ph = 0; ph < PHASES; ph++) begin
      write_capacity(PHASE_CAPS[ph]);
      tx_gaps = (ph != PRESSURE_PHASE) && (ph != PHASES - 1);
      rx_gaps = (ph != PHASES - 1);
      // Receiver holds off while the sender keeps offering: output and input fill.
      if (ph == PRESSURE_PHASE) hold_off_req = 1'b1;
      for (int j = 0; j < POOL; j++) pool[j] = $urandom;
      if ($urandom_range(0, 1)) pool[0] = 32'h8000_0000;
      if ($urandom_range(0, 1)) pool[1] = 32'h7FFF_FFFF;
      if ($urandom_range(0, 1)) pool[2] = 32'hFFFF_FFFF;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (tx_gaps && $urandom_range(0, 3) == 0) sender_gap($urandom_range(1, 17));
        if (ph == PAUSE_PHASE && n == ITEMS_PER_PHASE / 2) wait_for_results();
        k  = $urandom_range(0, 1) ? KIND_SET : KIND_GET;
        ky = ($urandom_range(0, 9) == 0) ? $urandom : pool[$urandom_range(0, PHASE_SPAN[ph] - 1)];
        v  = ($urandom_range(0, 7) == 0) ? EDGE_VALUES[$urandom_range(0, 3)] : $urandom;
        offer_item(k, ky, v, 1'b0, typed_res);
      end
    end

    // Drain: bounded wait for the last gets, then the tail of the final item.
    in_valid <= 1'b0;
    for (int w = 0; w < 20000 && pending_reads.size() != 0; w++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_reads.size() != 0) begin
      error_count += pending_reads.size();
      $display("%0d gets never answered", pending_reads.size());
    end

    $display("Ran %0d gets (%0d hits) and %0d sets with %0d evictions over %0d capacity writes",
             n_gets, n_hits, n_sets, n_evictions, n_cfg);
    $display("Checked %0d results, %0d mismatches", n_results, error_count);
    if (error_count == 0) begin
      $display("lru_key_value_cache test passed");
    end else begin
      $display("lru_key_value_cache test failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin : watchdog
    #4_000_000;
    $display("Run did not finish in time");
    $display("lru_key_value_cache test failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/lkv_pkg.sv
sv/lkv_store.sv
sv/lkv_recency.sv
sv/lru_key_value_cache.sv
sv/lru_key_value_cache_chk.sv
tb/tb_lru_key_value_cache.sv
